[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion violated");

// Property checked only at edges where reset is asserted.
`define ASSERT_IN_RESET(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) !rst_n |-> prop) \
		else $error("reset assertion violated");

`endif

[hdl/abd_pkg.sv]
package abd_pkg;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned RECT_W  = 24;
	localparam int unsigned CLASS_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_LABEL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIPROCAL = 2'd2;

	localparam logic [WORD_W-1:0] SCALE_RESET = 16'd512;

	localparam int unsigned JQ_DEPTH = 2;
	localparam int unsigned JQ_CNT_W = $clog2(JQ_DEPTH + 1);
	localparam int unsigned OQ_DEPTH = 2;

	// decode arithmetic widths
	localparam int unsigned P1_W        = 33;
	localparam int unsigned PROD_W      = 50;
	localparam int unsigned ROUND_SHIFT = 22;
	localparam int unsigned SCALED_W    = PROD_W - ROUND_SHIFT;
	localparam int unsigned COMP_W      = SCALED_W + 1;
	localparam int unsigned EDGE_W      = COMP_W + 1;
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'd1 << (ROUND_SHIFT - 1));

	localparam logic signed [EDGE_W-1:0] RECT_MAX = 30'sd8388607;
	localparam logic signed [EDGE_W-1:0] RECT_MIN = -30'sd8388608;

	typedef struct packed {
		logic                      found;
		logic signed [SCORE_W-1:0] score;
		logic [IDX_W-1:0]          index;
		logic [4*WORD_W-1:0]       raw;
		logic [4*WORD_W-1:0]       anchor;
	} job_t;

	typedef struct packed {
		logic                      found;
		logic signed [SCORE_W-1:0] score;
		logic [IDX_W-1:0]          index;
		logic signed [RECT_W-1:0]  left;
		logic signed [RECT_W-1:0]  top;
		logic signed [RECT_W-1:0]  width;
		logic signed [RECT_W-1:0]  height;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL1,
		BK_MUL2,
		BK_RND,
		BK_FIN
	} back_state_t;

	function automatic logic signed [RECT_W-1:0] sat_rect(input logic signed [EDGE_W-1:0] v);
		logic signed [RECT_W-1:0] r;
		if (v > RECT_MAX)
			r = 24'sh7FFFFF;
		else if (v < RECT_MIN)
			r = 24'sh800000;
		else
			r = v[RECT_W-1:0];
		return r;
	endfunction

endpackage

[hdl/abd_fifo.sv]
module abd_fifo import abd_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [WIDTH-1:0]               wr_data,
	input  logic                           rd_en,
	output logic [WIDTH-1:0]               rd_data,
	output logic                           empty,
	output logic                           full,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_ok, rd_ok;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_ok)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (wr_ok && !rd_ok)
				count_q <= count_q + CW'(1);
			else if (rd_ok && !wr_ok)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

[hdl/abd_front.sv]
module abd_front import abd_pkg::*; #(
	parameter int unsigned ANCHOR_COUNT = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      kind,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic                      frame_last,
	input  logic signed [SCORE_W-1:0] box_score,
	input  logic [WORD_W-1:0]         word_a,
	input  logic [WORD_W-1:0]         word_b,
	input  logic [WORD_W-1:0]         word_c,
	input  logic [WORD_W-1:0]         word_d,
	input  logic signed [SCORE_W-1:0] score_threshold,
	input  logic [JQ_CNT_W-1:0]       jq_count,
	output logic                      jq_push,
	output job_t                      jq_data
);

	localparam int unsigned AW = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
	localparam int unsigned XW = 13;
	localparam int unsigned CW = JQ_CNT_W + 1;

	logic [4*WORD_W-1:0] anchor_mem [ANCHOR_COUNT];

	logic                      best_valid_q;
	logic signed [SCORE_W-1:0] best_value_q;
	logic [IDX_W-1:0]          best_anchor_q;
	logic [4*WORD_W-1:0]       best_raw_q;

	logic                      valid_s1;
	logic                      found_s1;
	logic signed [SCORE_W-1:0] score_s1;
	logic [IDX_W-1:0]          index_s1;
	logic [4*WORD_W-1:0]       raw_s1;
	logic [4*WORD_W-1:0]       anchor_s1;

	logic                      accept, in_range, beats, take, snap;
	logic [XW-1:0]             idx_ext, rd_ext;
	logic [4*WORD_W-1:0]       packed_words;
	logic                      nb_valid;
	logic signed [SCORE_W-1:0] nb_value;
	logic [IDX_W-1:0]          nb_anchor;
	logic [4*WORD_W-1:0]       nb_raw;

	// hold off while the queued jobs plus the one in flight fill the job queue
	assign full = ({1'b0, jq_count} + CW'(valid_s1)) >= CW'(JQ_DEPTH);

	assign accept       = push && !full;
	assign idx_ext      = {{(XW-IDX_W){1'b0}}, entry_index};
	assign in_range     = idx_ext < XW'(ANCHOR_COUNT);
	assign packed_words = {word_d, word_c, word_b, word_a};
	assign beats        = (box_score > score_threshold) &&
	                      (!best_valid_q || (box_score > best_value_q));
	assign take         = accept && kind && in_range && beats;
	assign snap         = accept && kind && frame_last;

	// best box after the current item has been considered
	always_comb begin
		nb_valid  = best_valid_q;
		nb_value  = best_value_q;
		nb_anchor = best_anchor_q;
		nb_raw    = best_raw_q;
		if (take) begin
			nb_valid  = 1'b1;
			nb_value  = box_score;
			nb_anchor = entry_index;
			nb_raw    = packed_words;
		end
	end

	assign rd_ext = {{(XW-IDX_W){1'b0}}, nb_anchor};

	always_ff @(posedge clk) begin
		if (accept && !kind && in_range)
			anchor_mem[idx_ext[AW-1:0]] <= packed_words;
		if (snap)
			anchor_s1 <= anchor_mem[rd_ext[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q  <= 1'b0;
			best_value_q  <= '0;
			best_anchor_q <= '0;
			best_raw_q    <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= snap;
			if (snap) begin
				best_valid_q  <= 1'b0;
				best_value_q  <= '0;
				best_anchor_q <= '0;
				best_raw_q    <= '0;
			end else if (take) begin
				best_valid_q  <= nb_valid;
				best_value_q  <= nb_value;
				best_anchor_q <= nb_anchor;
				best_raw_q    <= nb_raw;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap) begin
			found_s1 <= nb_valid;
			score_s1 <= nb_value;
			index_s1 <= nb_anchor;
			raw_s1   <= nb_raw;
		end
	end

	assign jq_push        = valid_s1;
	assign jq_data.found  = found_s1;
	assign jq_data.score  = score_s1;
	assign jq_data.index  = index_s1;
	assign jq_data.raw    = raw_s1;
	assign jq_data.anchor = anchor_s1;

endmodule

[hdl/abd_back.sv]
module abd_back import abd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] scale_reciprocal,
	input  logic              jq_empty,
	input  job_t              jq_data,
	output logic              jq_pop,
	input  logic              oq_full,
	output logic              oq_push,
	output result_t           oq_data
);

	back_state_t state_q, state_d;

	job_t                     job_q;
	logic [1:0]               step_q;
	logic signed [P1_W-1:0]   p1_q;
	logic signed [PROD_W-1:0] p2_q;
	logic signed [COMP_W-1:0] comp_q [4];

	logic                       start;
	logic [WORD_W-1:0]          raw_sel, dim_sel, centre_sel;
	logic signed [P1_W-1:0]     p1_d;
	logic signed [PROD_W-1:0]   p2_d;
	logic [PROD_W-1:0]          biased;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [COMP_W-1:0]   scaled_ext, comp_d;
	logic signed [COMP_W-1:0]   half_w, half_h;
	logic signed [EDGE_W-1:0]   left_full, top_full;

	assign raw_sel    = job_q.raw[{step_q, 4'b0000} +: WORD_W];
	assign dim_sel    = step_q[0] ? job_q.anchor[63:48] : job_q.anchor[47:32];
	assign centre_sel = step_q[0] ? job_q.anchor[31:16] : job_q.anchor[15:0];

	assign p1_d = $signed(raw_sel) * $signed({1'b0, scale_reciprocal});
	assign p2_d = p1_q * $signed({1'b0, dim_sel});

	// round half up, then floor by the arithmetic shift
	assign biased     = p2_q + ROUND_BIAS;
	assign scaled     = biased[PROD_W-1:ROUND_SHIFT];
	assign scaled_ext = {scaled[SCALED_W-1], scaled};
	assign comp_d     = step_q[1] ? scaled_ext
	                              : scaled_ext + $signed({{(COMP_W-WORD_W){1'b0}}, centre_sel});

	assign half_w    = {comp_q[2][COMP_W-1], comp_q[2][COMP_W-1:1]};
	assign half_h    = {comp_q[3][COMP_W-1], comp_q[3][COMP_W-1:1]};
	assign left_full = {comp_q[0][COMP_W-1], comp_q[0]} - {half_w[COMP_W-1], half_w};
	assign top_full  = {comp_q[1][COMP_W-1], comp_q[1]} - {half_h[COMP_W-1], half_h};

	assign start = !jq_empty && !oq_full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (start) state_d = jq_data.found ? BK_MUL1 : BK_FIN;
			BK_MUL1: state_d = BK_MUL2;
			BK_MUL2: state_d = BK_RND;
			BK_RND:  state_d = (step_q == 2'd3) ? BK_FIN : BK_MUL1;
			BK_FIN:  state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		jq_pop  = 1'b0;
		oq_push = 1'b0;
		unique case (state_q)
			BK_IDLE: jq_pop = start;
			BK_FIN:  oq_push = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (jq_pop)
				step_q <= '0;
			else if (state_q == BK_RND)
				step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (jq_pop)
			job_q <= jq_data;
		if (state_q == BK_MUL1)
			p1_q <= p1_d;
		if (state_q == BK_MUL2)
			p2_q <= p2_d;
		if (state_q == BK_RND)
			comp_q[step_q] <= comp_d;
	end

	always_comb begin
		oq_data = '0;
		if (job_q.found) begin
			oq_data.found  = 1'b1;
			oq_data.score  = job_q.score;
			oq_data.index  = job_q.index;
			oq_data.left   = sat_rect(left_full);
			oq_data.top    = sat_rect(top_full);
			oq_data.width  = sat_rect({comp_q[2][COMP_W-1], comp_q[2]});
			oq_data.height = sat_rect({comp_q[3][COMP_W-1], comp_q[3]});
		end
	end

endmodule

[hdl/anchor_box_decode_best_score_top.sv]
// Best-score anchor box decoder. Items enter through a queue-style port
// (push/full): kind 0 writes one anchor (centre x, centre y, width, height,
// Q0.16 each) into an ANCHOR_COUNT-entry table; kind 1 offers a scored raw
// box (signed Q9.6 words). Within a frame a box whose score is strictly
// above both score_threshold and the best kept score replaces the kept one,
// so a tie keeps the earlier box; the box item with frame_last set ends the
// frame and yields exactly one result on the pop/empty port: found, score,
// class, anchor index and a corner-form rectangle in signed Q7.16, saturated
// to 24 bits (all zero but class when nothing beat the threshold). Rate:
// while full is low the front takes one item per cycle, anchor loads and
// boxes alike; a frame end snapshots the kept box and its anchor at the
// accepting edge, so anchor writes after the frame end do not touch that
// frame. Per kept box the back runs MUL1, MUL2 and RND on each of the four
// coordinates. A two-entry job queue lets the front keep streaming, and full
// rises only while two frame ends wait for the back, that is when frame ends
// outrun the decoder or when results back up behind an unpopped output
// queue. Results wait in a two-entry output queue. The user must see that
// configuration (cfg_valid/cfg_ready, always ready) is written only while
// the block holds no pending work; the block does not enforce it.
module anchor_box_decode_best_score_top import abd_pkg::*; #(
	parameter int unsigned ANCHOR_COUNT = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item input
	input  logic                      push,
	output logic                      full,
	input  logic                      kind,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic                      frame_last,
	input  logic signed [SCORE_W-1:0] box_score,
	input  logic [WORD_W-1:0]         word_a,
	input  logic [WORD_W-1:0]         word_b,
	input  logic [WORD_W-1:0]         word_c,
	input  logic [WORD_W-1:0]         word_d,
	// result output
	output logic                      empty,
	input  logic                      pop,
	output logic                      found,
	output logic signed [SCORE_W-1:0] best_score,
	output logic [CLASS_W-1:0]        class_out,
	output logic [IDX_W-1:0]          winner_index,
	output logic signed [RECT_W-1:0]  rect_left,
	output logic signed [RECT_W-1:0]  rect_top,
	output logic signed [RECT_W-1:0]  rect_width,
	output logic signed [RECT_W-1:0]  rect_height,
	// configuration write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [WORD_W-1:0]         cfg_data
);

	logic signed [SCORE_W-1:0] score_threshold_q;
	logic [CLASS_W-1:0]        class_label_q;
	logic [WORD_W-1:0]         scale_reciprocal_q;

	logic                jq_push, jq_pop, jq_empty;
	logic [JQ_CNT_W-1:0] jq_count;
	job_t                jq_wr_data, jq_rd_data;
	logic                oq_push, oq_full;
	result_t             oq_wr_data, oq_rd_data;

	// Configuration registers: the write always completes, unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_threshold_q  <= '0;
			class_label_q      <= '0;
			scale_reciprocal_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCORE_THRESHOLD:  score_threshold_q  <= cfg_data;
				CFG_CLASS_LABEL:      class_label_q      <= cfg_data[CLASS_W-1:0];
				CFG_SCALE_RECIPROCAL: scale_reciprocal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: anchor table, best-score tracking, frame-end snapshot.
	abd_front #(
		.ANCHOR_COUNT(ANCHOR_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.entry_index    (entry_index),
		.frame_last     (frame_last),
		.box_score      (box_score),
		.word_a         (word_a),
		.word_b         (word_b),
		.word_c         (word_c),
		.word_d         (word_d),
		.score_threshold(score_threshold_q),
		.jq_count       (jq_count),
		.jq_push        (jq_push),
		.jq_data        (jq_wr_data)
	);

	// Job queue: decouple frame ends from the decoder.
	abd_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JQ_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (jq_push),
		.wr_data(jq_wr_data),
		.rd_en  (jq_pop),
		.rd_data(jq_rd_data),
		.empty  (jq_empty),
		.full   (),
		.count  (jq_count)
	);

	// Back: sequential decode of the four coordinates in turn.
	abd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.scale_reciprocal(scale_reciprocal_q),
		.jq_empty        (jq_empty),
		.jq_data         (jq_rd_data),
		.jq_pop          (jq_pop),
		.oq_full         (oq_full),
		.oq_push         (oq_push),
		.oq_data         (oq_wr_data)
	);

	// Output queue: hold finished results until popped.
	abd_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OQ_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (oq_push),
		.wr_data(oq_wr_data),
		.rd_en  (pop),
		.rd_data(oq_rd_data),
		.empty  (empty),
		.full   (oq_full),
		.count  ()
	);

	assign found        = oq_rd_data.found;
	assign best_score   = oq_rd_data.score;
	assign class_out    = class_label_q;
	assign winner_index = oq_rd_data.index;
	assign rect_left    = oq_rd_data.left;
	assign rect_top     = oq_rd_data.top;
	assign rect_width   = oq_rd_data.width;
	assign rect_height  = oq_rd_data.height;

endmodule

[hdl/abd_checker.sv]
`include "assert_macros.svh"

module abd_checker import abd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      full,
	input logic                      empty,
	input logic                      pop,
	input logic                      found,
	input logic signed [SCORE_W-1:0] best_score,
	input logic [IDX_W-1:0]          winner_index,
	input logic signed [RECT_W-1:0]  rect_left,
	input logic signed [RECT_W-1:0]  rect_top,
	input logic signed [RECT_W-1:0]  rect_width,
	input logic signed [RECT_W-1:0]  rect_height
);

	localparam int unsigned PAYLOAD_W = 1 + SCORE_W + IDX_W + 4 * RECT_W;

	logic                 zero_fields;
	logic [PAYLOAD_W-1:0] payload;

	assign zero_fields = (best_score == '0) && (winner_index == '0) &&
	                     (rect_left == '0) && (rect_top == '0) &&
	                     (rect_width == '0) && (rect_height == '0);
	assign payload     = {found, best_score, winner_index,
	                      rect_left, rect_top, rect_width, rect_height};

	// reset leaves no result waiting and the input open
	`ASSERT_IN_RESET(a_reset_idle, clk, arst_n, empty && !full)

	// a frame without a kept box reports zeros
	`ASSERT_CLK(a_none_zero, clk, arst_n, (!empty && !found) |-> zero_fields)

	// a waiting result holds until popped
	`ASSERT_CLK(a_result_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(payload)))

endmodule

bind anchor_box_decode_best_score_top abd_checker u_abd_checker (.*);

[test/best_box_sb_pkg.sv]
`timescale 1ns / 1ps
package best_box_sb_pkg;
	import abd_pkg::*;

	localparam int unsigned TABLE_DEPTH  = 1024;
	localparam int unsigned REPORT_LIMIT = 10;

	localparam logic KIND_ANCHOR = 1'b0;
	localparam logic KIND_BOX    = 1'b1;

	typedef struct packed {
		logic                      kind;
		logic [IDX_W-1:0]          index;
		logic                      last;
		logic signed [SCORE_W-1:0] score;
		logic [WORD_W-1:0]         wa;
		logic [WORD_W-1:0]         wb;
		logic [WORD_W-1:0]         wc;
		logic [WORD_W-1:0]         wd;
	} box_item_t;

	typedef struct packed {
		logic                      found;
		logic signed [SCORE_W-1:0] score;
		logic [CLASS_W-1:0]        cls;
		logic [IDX_W-1:0]          index;
		logic signed [RECT_W-1:0]  left;
		logic signed [RECT_W-1:0]  top;
		logic signed [RECT_W-1:0]  width;
		logic signed [RECT_W-1:0]  height;
	} detection_t;

	class detection_predictor;
		logic [4*WORD_W-1:0]       anchors [TABLE_DEPTH];
		logic                      kept;
		logic signed [SCORE_W-1:0] kept_score;
		logic [IDX_W-1:0]          kept_index;
		logic [4*WORD_W-1:0]       kept_raw;
		logic signed [SCORE_W-1:0] threshold;
		logic [CLASS_W-1:0]        label;
		logic [WORD_W-1:0]         scale;
		detection_t                expected_detections [$];
		int unsigned               mismatches;

		function new();
			foreach (anchors[i])
				anchors[i] = '0;
			kept       = 1'b0;
			kept_score = '0;
			kept_index = '0;
			kept_raw   = '0;
			threshold  = '0;
			label      = '0;
			scale      = SCALE_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
			case (idx)
			CFG_SCORE_THRESHOLD: begin
				threshold = data;
			end
			CFG_CLASS_LABEL: begin
				label = data[CLASS_W-1:0];
			end
			CFG_SCALE_RECIPROCAL: begin
				scale = data;
			end
			default: begin
			end
			endcase
		endfunction

		// raw * scale * dim carries 38 fraction bits; round half up to 16
		function longint scale_word(logic [WORD_W-1:0] raw, logic [WORD_W-1:0] dim);
			longint r;
			longint s;
			longint d;
			longint p;
			r = longint'($signed(raw));
			s = scale;
			d = dim;
			p = r * s * d;
			return (p + (longint'(1) <<< 21)) >>> 22;
		endfunction

		function logic signed [RECT_W-1:0] clip_rect(longint v);
			if (v > longint'(8388607))
				return 24'sh7FFFFF;
			if (v < -longint'(8388608))
				return 24'sh800000;
			return v[RECT_W-1:0];
		endfunction

		function void note_item(box_item_t it);
			detection_t          d;
			logic [4*WORD_W-1:0] words;
			logic [4*WORD_W-1:0] a;
			longint              acx;
			longint              acy;
			longint              cx;
			longint              cy;
			longint              w;
			longint              h;
			words = {it.wd, it.wc, it.wb, it.wa};
			if (it.kind == KIND_ANCHOR) begin
				if (it.index < TABLE_DEPTH)
					anchors[it.index] = words;
				return;
			end
			if (it.index < TABLE_DEPTH && it.score > threshold &&
			    (!kept || it.score > kept_score)) begin
				kept       = 1'b1;
				kept_score = it.score;
				kept_index = it.index;
				kept_raw   = words;
			end
			if (!it.last)
				return;
			d     = '0;
			d.cls = label;
			if (kept) begin
				a   = anchors[kept_index];
				acx = a[15:0];
				acy = a[31:16];
				cx  = scale_word(kept_raw[15:0], a[47:32]) + acx;
				cy  = scale_word(kept_raw[31:16], a[63:48]) + acy;
				w   = scale_word(kept_raw[47:32], a[47:32]);
				h   = scale_word(kept_raw[63:48], a[63:48]);
				d.found  = 1'b1;
				d.score  = kept_score;
				d.index  = kept_index;
				d.left   = clip_rect(cx - (w >>> 1));
				d.top    = clip_rect(cy - (h >>> 1));
				d.width  = clip_rect(w);
				d.height = clip_rect(h);
			end
			expected_detections.insert(expected_detections.size(), d);
			kept       = 1'b0;
			kept_score = '0;
			kept_index = '0;
			kept_raw   = '0;
		endfunction

		function void check_detection(detection_t got);
			detection_t want;
			if (expected_detections.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected detection: found=%0b score=%0d index=%0d",
					         got.found, got.score, got.index);
				return;
			end
			want = expected_detections.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("detection mismatch, expected: found=%0b score=%0d class=%0d",
					         want.found, want.score, want.cls);
					$display("  index=%0d rect=(%0d %0d %0d %0d)", want.index,
					         want.left, want.top, want.width, want.height);
					$display("  actual: found=%0b score=%0d class=%0d index=%0d",
					         got.found, got.score, got.cls, got.index);
					$display("  rect=(%0d %0d %0d %0d)",
					         got.left, got.top, got.width, got.height);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_detections.size();
		endfunction
	endclass

endpackage

[test/tb_anchor_box_decode_best_score_top.sv]
`timescale 1ns / 1ps
module tb_anchor_box_decode_best_score_top;
	import abd_pkg::*;
	import best_box_sb_pkg::*;

	// cycles with no accepted item before the run is declared hung
	localparam int unsigned STALL_LIMIT   = 4000;
	// length of the deliberate receiver hold-off that fills the block
	localparam int unsigned HOLD_CYCLES   = 400;
	// drain margin: job queue, decode and output queue
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned PHASE_ITEMS   = 130;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	logic                      kind;
	logic [IDX_W-1:0]          entry_index;
	logic                      frame_last;
	logic signed [SCORE_W-1:0] box_score;
	logic [WORD_W-1:0]         word_a;
	logic [WORD_W-1:0]         word_b;
	logic [WORD_W-1:0]         word_c;
	logic [WORD_W-1:0]         word_d;
	logic                      empty;
	logic                      pop;
	logic                      found;
	logic signed [SCORE_W-1:0] best_score;
	logic [CLASS_W-1:0]        class_out;
	logic [IDX_W-1:0]          winner_index;
	logic signed [RECT_W-1:0]  rect_left;
	logic signed [RECT_W-1:0]  rect_top;
	logic signed [RECT_W-1:0]  rect_width;
	logic signed [RECT_W-1:0]  rect_height;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [WORD_W-1:0]         cfg_data;

	detection_predictor        predictor;
	int unsigned               send_idle_pct;
	int unsigned               pop_stall_pct;
	bit                        hold_req;
	int unsigned               quiet_cycles;
	bit                        moved;
	bit                        written [TABLE_DEPTH];
	int unsigned               written_idx [$];
	logic [SCORE_W-1:0]        last_score;

	anchor_box_decode_best_score_top #(
		.ANCHOR_COUNT(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.entry_index(entry_index),
		.frame_last(frame_last),
		.box_score(box_score),
		.word_a(word_a),
		.word_b(word_b),
		.word_c(word_c),
		.word_d(word_d),
		.empty(empty),
		.pop(pop),
		.found(found),
		.best_score(best_score),
		.class_out(class_out),
		.winner_index(winner_index),
		.rect_left(rect_left),
		.rect_top(rect_top),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Sample both handshakes at the rising edge; inputs only move at the
	// falling edge, so the values seen here are the ones the block takes.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				predictor.note_item('{kind, entry_index, frame_last, box_score,
				                      word_a, word_b, word_c, word_d});
				moved = 1'b1;
			end
			if (pop && !empty) begin
				predictor.check_detection('{found, best_score, class_out, winner_index,
				                            rect_left, rect_top, rect_width, rect_height});
				moved = 1'b1;
			end
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					pop <= 1'b0;
					@(negedge clk);
				end
			end
			pop <= ($urandom_range(99) < pop_stall_pct) ? 1'b0 : 1'b1;
		end
	end

	function automatic box_item_t make_item(logic k, logic [IDX_W-1:0] idx, logic last,
	                                         logic [SCORE_W-1:0] score,
	                                         logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
	                                         logic [WORD_W-1:0] c, logic [WORD_W-1:0] d);
		box_item_t it;
		it.kind  = k;
		it.index = idx;
		it.last  = last;
		it.score = score;
		it.wa    = a;
		it.wb    = b;
		it.wc    = c;
		it.wd    = d;
		return it;
	endfunction

	// Mostly full-range words, with zero, all ones and the corners of the signed range mixed in.
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(15))
		0: return 16'h0000;
		1: return 16'h7FFF;
		2: return 16'h8000;
		3: return 16'hFFFF;
		default: return WORD_W'($urandom);
		endcase
	endfunction

	// Scores: full range, hugging the threshold, or a repeat to force ties.
	function automatic logic [SCORE_W-1:0] random_score();
		int                 v;
		logic [SCORE_W-1:0] s;
		case ($urandom_range(4))
		0, 1: begin
			s = SCORE_W'($urandom);
		end
		2, 3: begin
			v = int'(predictor.threshold) + int'($urandom_range(8)) - 4;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			s = SCORE_W'(v);
		end
		default: begin
			s = last_score;
		end
		endcase
		last_score = s;
		return s;
	endfunction

	// Boxes only point at anchors already loaded, so no unwritten entry is read.
	function automatic box_item_t random_box(logic last);
		logic [IDX_W-1:0] idx;
		idx = IDX_W'(written_idx[$urandom_range(written_idx.size() - 1)]);
		return make_item(KIND_BOX, idx, last, random_score(),
		                 random_word(), random_word(), random_word(), random_word());
	endfunction

	function automatic box_item_t random_anchor(logic last);
		return make_item(KIND_ANCHOR, IDX_W'($urandom_range(TABLE_DEPTH - 1)), last,
		                 SCORE_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
		                 WORD_W'($urandom), WORD_W'($urandom));
	endfunction

	// Offer one item, with random idle cycles ahead of it; hold until taken.
	task automatic send_item(box_item_t it);
		if (it.kind == KIND_ANCHOR && !written[it.index]) begin
			written[it.index] = 1'b1;
			written_idx.insert(written_idx.size(), 32'(it.index));
		end
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		kind        <= it.kind;
		entry_index <= it.index;
		frame_last  <= it.last;
		box_score   <= it.score;
		word_a      <= it.wa;
		word_b      <= it.wb;
		word_c      <= it.wc;
		word_d      <= it.wd;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		predictor.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop push, drain every expected detection, then let the back end go quiet.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Random frames of up to max_len items; a few anchor loads ride inside,
	// some flagged last to check that they end nothing. Close with a frame end.
	task automatic run_frames(int unsigned count, int unsigned max_len);
		int unsigned sent;
		int unsigned len;
		int unsigned roll;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(max_len, 1);
			for (int unsigned k = 0; k < len; k++) begin
				roll = $urandom_range(99);
				if (roll < 12)
					send_item(random_anchor(roll < 3));
				else
					send_item(random_box(k == len - 1));
				sent++;
			end
		end
		send_item(random_box(1'b1));
	endtask

	initial begin
		logic [WORD_W-1:0]  thr_tab [PHASES];
		logic [WORD_W-1:0]  cls_tab [PHASES];
		logic [WORD_W-1:0]  scl_tab [PHASES];
		int unsigned        send_tab [PHASES];
		int unsigned        stall_tab [PHASES];
		int unsigned        len_tab [PHASES];

		predictor     = new();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		hold_req      = 1'b0;
		quiet_cycles  = 0;
		last_score    = '0;
		arst_n        = 1'b0;
		push          = 1'b0;
		kind          = KIND_ANCHOR;
		entry_index   = '0;
		frame_last    = 1'b0;
		box_score     = '0;
		word_a        = '0;
		word_b        = '0;
		word_c        = '0;
		word_d        = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_SCORE_THRESHOLD;
		cfg_data      = '0;

		// extremes first, then random settings and idle mixes
		thr_tab   = '{16'h8000, 16'h7FFF, 16'h0100, WORD_W'($urandom), 16'hFF00, 16'h0000};
		cls_tab   = '{16'h00FF, 16'h0000, 16'h00A5, WORD_W'($urandom_range(255)), 16'h005A,
		              WORD_W'($urandom_range(255))};
		scl_tab   = '{16'd1, 16'hFFFF, 16'hFFFF, WORD_W'($urandom_range(65535, 1)), 16'h0200,
		              16'h0100};
		send_tab  = '{0, 73, 0, 32, 0, 32};
		stall_tab = '{0, 0, 73, 32, 0, 32};
		len_tab   = '{10, 8, 10, 6, 3, 10};

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under reset configuration (threshold 0, scale 512).
		// Anchors at both ends of the table and at alternating bit patterns.
		send_item(make_item(KIND_ANCHOR, 10'd0, 1'b0, 16'h0000,
		                    16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
		send_item(make_item(KIND_ANCHOR, 10'd1023, 1'b0, 16'hFFFF,
		                    16'hFFFF, 16'hFFFF, 16'h8000, 16'h4000));
		send_item(make_item(KIND_ANCHOR, 10'h2AA, 1'b0, 16'h0000,
		                    16'h8000, 16'h8000, 16'h1000, 16'h2000));
		// frame end flag on an anchor load: writes, yields nothing
		send_item(make_item(KIND_ANCHOR, 10'h155, 1'b1, 16'h0000,
		                    16'h4000, 16'hC000, 16'hFFFF, 16'h0001));
		// score equal to the threshold is not kept: empty detection
		send_item(make_item(KIND_BOX, 10'd0, 1'b1, 16'h0000,
		                    16'h1234, 16'h1234, 16'h1234, 16'h1234));
		// first box kept, a tie does not replace it, a higher score does
		send_item(make_item(KIND_BOX, 10'd1023, 1'b0, 16'h0001,
		                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_item(make_item(KIND_BOX, 10'd0, 1'b0, 16'h0001,
		                    16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_item(make_item(KIND_BOX, 10'h2AA, 1'b0, 16'h7FFF,
		                    16'h8000, 16'h8000, 16'h8000, 16'h8000));
		// rewrite the winner's anchor mid-frame: decode sees the new one
		send_item(make_item(KIND_ANCHOR, 10'h2AA, 1'b0, 16'h0000,
		                    16'h1234, 16'h5678, 16'hFFFF, 16'hFFFF));
		send_item(make_item(KIND_BOX, 10'h155, 1'b1, 16'hFFFB,
		                    16'h0000, 16'h0000, 16'h0000, 16'h0000));
		// most negative score never beats the threshold
		send_item(make_item(KIND_BOX, 10'd0, 1'b1, 16'h8000,
		                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		// unit offsets of both signs
		send_item(make_item(KIND_BOX, 10'h155, 1'b1, 16'h0080,
		                    16'h0040, 16'hFFC0, 16'h0040, 16'h0040));
		// smallest raw magnitudes of both signs, exercising rounding
		send_item(make_item(KIND_BOX, 10'd1023, 1'b1, 16'h7FFF,
		                    16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
		settle();

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_SCORE_THRESHOLD, thr_tab[ph]);
			write_reg(CFG_CLASS_LABEL, cls_tab[ph]);
			write_reg(CFG_SCALE_RECIPROCAL, scl_tab[ph]);
			send_idle_pct = send_tab[ph];
			pop_stall_pct = stall_tab[ph];
			// short frames with a blocked receiver back the block up to full
			if (len_tab[ph] == 3)
				hold_req = 1'b1;
			run_frames(PHASE_ITEMS, len_tab[ph]);
			settle();
		end

		if (predictor.mismatches == 0 && predictor.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
